[hw/rtl/txsq_pkg.sv]
package txsq_pkg;

  // Largest declared payload length; longer declarations are clipped to it.
  localparam int MAX_PAYLOAD = 128;

  localparam int HDR_BYTES   = 17;
  localparam int FIXED_BYTES = 18;

  localparam logic [7:0] TAG_DOLLAR = 8'h24;
  localparam logic [7:0] TAG_T      = 8'h54;
  localparam logic [7:0] TAG_X      = 8'h58;
  localparam logic [7:0] TAG_S      = 8'h53;
  localparam logic [7:0] TAG_Q      = 8'h51;
  localparam logic [7:0] KIND_TEXT  = 8'h44;
  localparam logic [7:0] KIND_CODE  = 8'h46;
  localparam logic [7:0] ACK_NONE   = 8'h00;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        frame_start;
    logic        frame_end;
    logic [7:0]  payload_length;
    logic [23:0] destination_address;
    logic        message_kind;
  } msg_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frm_item_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic        start;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  len;
    logic [23:0] dest;
    logic        kind;
  } cmd_t;

endpackage

[hw/rtl/txsq_front.sv]
module txsq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  input  txsq_pkg::msg_item_t msg,
  input  logic                msg_stall,
  output logic                push,
  output txsq_pkg::cmd_t      push_cmd
);
  import txsq_pkg::*;

  localparam logic [13:0] MAX_LEN = 14'(MAX_PAYLOAD);

  logic inside_frame;
  logic take;
  logic clip;

  assign take = msg_valid && !msg_stall;
  assign clip = {6'b0, msg.payload_length} > MAX_LEN;

  // Bytes that arrive while no frame is open and do not start one are dropped.
  assign push = take && (msg.frame_start || inside_frame);

  always_comb begin
    push_cmd.start = msg.frame_start;
    push_cmd.last  = msg.frame_end;
    push_cmd.data  = msg.payload_byte;
    push_cmd.len   = clip ? MAX_LEN[7:0] : msg.payload_length;
    push_cmd.dest  = msg.destination_address;
    push_cmd.kind  = msg.message_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
    end else if (push) begin
      inside_frame <= !msg.frame_end;
    end
  end

endmodule

[hw/rtl/txsq_queue.sv]
module txsq_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  txsq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output txsq_pkg::cmd_t head
);
  import txsq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == FULL_CNT;
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/txsq_back.sv]
module txsq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [23:0]         source_address,
  input  logic                head_valid,
  input  txsq_pkg::cmd_t      head,
  output logic                pop,
  output logic                frm_valid,
  output txsq_pkg::frm_item_t frm,
  input  logic                frm_stall
);
  import txsq_pkg::*;

  typedef enum logic [1:0] {
    ST_HEAD,
    ST_BODY,
    ST_SUM
  } step_t;

  localparam logic [4:0] HDR_END = 5'(HDR_BYTES - 1);

  step_t      step;
  logic [4:0] idx;
  logic [7:0] running_xor;
  logic       adv;
  logic       in_hdr;
  logic       in_sum;
  logic [8:0] total;
  logic [10:0] bits;
  logic [7:0] hdr_byte;

  assign adv    = !frm_valid || !frm_stall;
  assign in_hdr = (step == ST_HEAD) && head.start;
  assign in_sum = step == ST_SUM;
  assign total  = {1'b0, head.len} + 9'(FIXED_BYTES);
  assign bits   = {head.len, 3'b000};

  // The entry leaves the queue after its payload byte, or after the
  // checksum when it closes the frame.
  assign pop = adv && head_valid && (in_sum || (!in_hdr && !head.last));

  always_comb begin
    case (idx)
      5'd0:    hdr_byte = TAG_DOLLAR;
      5'd1:    hdr_byte = TAG_T;
      5'd2:    hdr_byte = TAG_X;
      5'd3:    hdr_byte = TAG_S;
      5'd4:    hdr_byte = TAG_Q;
      5'd5:    hdr_byte = {7'b0, total[8]};
      5'd6:    hdr_byte = total[7:0];
      5'd7:    hdr_byte = source_address[23:16];
      5'd8:    hdr_byte = source_address[15:8];
      5'd9:    hdr_byte = source_address[7:0];
      5'd10:   hdr_byte = head.kind ? KIND_CODE : KIND_TEXT;
      5'd11:   hdr_byte = head.dest[23:16];
      5'd12:   hdr_byte = head.dest[15:8];
      5'd13:   hdr_byte = head.dest[7:0];
      5'd14:   hdr_byte = {5'b0, bits[10:8]};
      5'd15:   hdr_byte = bits[7:0];
      default: hdr_byte = ACK_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_HEAD;
      idx         <= '0;
      running_xor <= '0;
      frm_valid   <= 1'b0;
    end else if (adv) begin
      frm_valid <= head_valid;
      if (head_valid) begin
        if (in_hdr) begin
          frm.frame_byte <= hdr_byte;
          frm.frame_last <= 1'b0;
          // A new header restarts the checksum, even over an abandoned frame.
          running_xor    <= (idx == '0) ? hdr_byte : running_xor ^ hdr_byte;
          if (idx == HDR_END) begin
            idx  <= '0;
            step <= ST_BODY;
          end else begin
            idx <= idx + 1'b1;
          end
        end else if (in_sum) begin
          frm.frame_byte <= running_xor;
          frm.frame_last <= 1'b1;
          running_xor    <= '0;
          step           <= ST_HEAD;
        end else begin
          frm.frame_byte <= head.data;
          frm.frame_last <= 1'b0;
          running_xor    <= running_xor ^ head.data;
          step           <= head.last ? ST_SUM : ST_HEAD;
        end
      end
    end
  end

endmodule

[hw/rtl/txsq_message_framer_unit.sv]
// TXSQ short-message framer.
// The msg channel (msg_valid, msg_stall, msg) takes payload bytes; an item is
// taken at a clock edge with msg_valid high and msg_stall low. The frm
// channel (frm_valid, frm_stall, frm) delivers framed command bytes in the
// same way, with frame_last high on the closing checksum byte.
// The cfg channel writes the 24-bit source address; the user must do so only
// while the block is idle (not enforced by the block); cfg_ready is always high.
// A front stage classifies each byte and drops those that arrive outside a
// frame; kept items wait in a small queue of QUEUE_DEPTH entries, from which
// the back stage emits one byte per cycle into an output register while
// frm_stall is low. With the queue empty, a taken item is written into a
// queue slot and then its first output byte into the output register. A
// starting byte follows the seventeen-byte header, and a closing byte is
// followed by the checksum byte; between headers the sustained rate is one
// payload byte per cycle while frm_stall is low, set by the single output
// register; the queue absorbs input during header bursts, then stalls it.
// When frm_stall is high the output holds and the queue fills; once full,
// msg_stall rises. Synchronous reset empties the queue, closes any open frame
// and clears the source address to zero.
module txsq_message_framer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_stall,
  input  txsq_pkg::msg_item_t msg,
  output logic                frm_valid,
  input  logic                frm_stall,
  output txsq_pkg::frm_item_t frm,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_data
);
  import txsq_pkg::*;

  logic [23:0] source_address;
  logic        push;
  cmd_t        push_cmd;
  logic        full;
  logic        pop;
  logic        head_valid;
  cmd_t        head;

  assign cfg_ready = 1'b1;
  assign msg_stall = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      source_address <= cfg_data;
    end
  end

  txsq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .msg_valid(msg_valid),
    .msg      (msg),
    .msg_stall(msg_stall),
    .push     (push),
    .push_cmd (push_cmd)
  );

  txsq_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  txsq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .source_address(source_address),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .frm_valid     (frm_valid),
    .frm           (frm),
    .frm_stall     (frm_stall)
  );

endmodule
